[rtl/ttma_pkg.sv]
package ttma_pkg;

    // Field widths
    localparam int unsigned ID_W    = 8;
    localparam int unsigned RAW_W   = 32;
    localparam int unsigned CAP_W   = 29;
    localparam int unsigned AVG_W   = 32;
    localparam int unsigned WT_W    = 8;
    localparam int unsigned WATCH_W = 9;

    // Tick conversion: cap = (raw + 4) >> 3
    localparam logic [RAW_W-1:0] ROUND_ADD = 32'd4;
    localparam int unsigned      CAP_SHIFT = 3;

    // Weight limits, in parts of 200
    localparam logic [WT_W-1:0] W_FULL  = 8'd200;
    localparam logic [WT_W-1:0] W_FLOOR = 8'd20;
    localparam logic [WT_W-1:0] W_STEP  = 8'd2;
    localparam logic [WT_W-1:0] W_LOW   = 8'd18;

    // Largest value that can enter the average without overflow
    localparam logic [AVG_W-1:0] AVG_LIMIT = 32'd21474836;
    localparam logic [AVG_W-1:0] AVG_SAT   = 32'hFFFF_FFFF;

    // Product datapath: operands below the limit fit 25 bits
    localparam int unsigned MUL_IN_W = 25;
    localparam int unsigned ACC_W    = 33;
    localparam int unsigned SUM_W    = ACC_W - 3;

    // Divide by 25 after the shift by 3: q = (x * RECIP_M) >> RECIP_SHIFT
    localparam int unsigned      RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP_M   = 31'd1374389535;
    localparam int unsigned      RECIP_SHIFT = 35;
    localparam int unsigned      PROD_W      = SUM_W + RECIP_W;
    localparam int unsigned      QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [WATCH_W-1:0] WATCH_NONE = 9'd256;

    // Output word layout
    localparam int unsigned M_TDATA_W = 104;
    localparam int unsigned M_TUSER_W = 2;

    // One classified word in the queue
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CAP_W-1:0] cap;
        logic             ok;
        logic             hit;
    } item_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // One row of the per-task table
    typedef struct packed {
        logic [CAP_W-1:0] max_time;
        logic [AVG_W-1:0] avg_time;
        logic [WT_W-1:0]  weight;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_WRITE
    } back_state_t;

endpackage

[rtl/ttma_front.sv]
module ttma_front
    import ttma_pkg::*;
#(
    parameter int unsigned NUM_TASKS        = 32,
    parameter int unsigned NUM_IRQ_CHANNELS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [WATCH_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,   // task_id [7:0], raw_ticks [39:8]
    input  logic               s_tuser,   // opcode
    output logic               q_push,
    output item_t              q_item,
    input  q_stat_t            q_stat
);

    logic [WATCH_W-1:0] watch_reg;
    logic [WATCH_W-1:0] watch_next;
    logic [ID_W-1:0]    id;
    logic [RAW_W-1:0]   rounded;
    logic [WATCH_W-1:0] id_ext;
    logic               task_ok;
    logic               irq_ok;
    logic               ok;

    // Watch register
    always_comb begin
        watch_next = cfg_we ? cfg_wdata : watch_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            watch_reg <= WATCH_NONE;
        end else begin
            watch_reg <= watch_next;
        end
    end

    // Classify the incoming word
    assign id      = s_tdata[ID_W-1:0];
    assign rounded = s_tdata[ID_W +: RAW_W] + ROUND_ADD;
    assign id_ext  = {1'b0, id};
    assign task_ok = id_ext < WATCH_W'(NUM_TASKS);
    assign irq_ok  = id_ext < WATCH_W'(NUM_IRQ_CHANNELS);
    assign ok      = task_ok && (!s_tuser || irq_ok);

    assign q_item.id  = id;
    assign q_item.cap = rounded[RAW_W-1:CAP_SHIFT];
    assign q_item.ok  = ok;
    assign q_item.hit = ok && (id_ext == watch_reg);

    // Take a word whenever the queue has room
    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;

endmodule

[rtl/ttma_fifo.sv]
module ttma_fifo
    import ttma_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_push,
    input  item_t   q_item_in,
    input  logic    q_pop,
    output item_t   q_item_out,
    output q_stat_t q_stat
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = q_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (q_push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (q_pop && !q_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (q_push) begin
            slot_reg[wr_ptr_reg] <= q_item_in;
        end
    end

    assign q_item_out   = slot_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == 2'd2;
    assign q_stat.empty = count_reg == 2'd0;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not follow a push");

endmodule

[rtl/ttma_back.sv]
module ttma_back
    import ttma_pkg::*;
#(
    parameter int unsigned NUM_TASKS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_stat_t              q_stat,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    back_state_t state_reg;
    back_state_t state_next;

    entry_t                  mem [NUM_TASKS];
    logic [NUM_TASKS-1:0]    valid_reg;
    logic [NUM_TASKS-1:0]    valid_next;
    entry_t                  rd_data_reg;
    logic                    rd_valid_reg;
    item_t                   job_reg;
    logic [IDX_W-1:0]        job_idx;
    logic [IDX_W-1:0]        head_idx;

    logic [ACC_W-1:0]        prod_a_reg;
    logic [ACC_W-1:0]        prod_b_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [PROD_W-1:0]       quot_reg;
    logic [CAP_W-1:0]        max_new_reg;
    logic [WT_W-1:0]         wt_new_reg;
    logic                    sat_reg;
    logic [CAP_W-1:0]        watched_capture_reg;

    entry_t                  cur;
    logic [WT_W-1:0]         w_clamp;
    logic                    sat;
    logic [ACC_W-1:0]        acc;
    entry_t                  wr_entry;

    logic                    out_free;
    logic                    load;
    logic                    wr_en;

    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic [M_TUSER_W-1:0]    m_tuser_reg;

    assign job_idx  = job_reg.id[IDX_W-1:0];
    assign head_idx = q_item.id[IDX_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer: pop, read and multiply, sum, divide, write back; an ignored word goes from pop straight to write
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop      = 1'b1;
                    state_next = q_item.ok ? ST_READ : ST_WRITE;
                end
            end
            ST_READ:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_DIV;
            ST_DIV:   state_next = ST_WRITE;
            ST_WRITE: begin
                if (out_free) begin
                    load       = 1'b1;
                    wr_en      = job_reg.ok;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Table memory with registered read
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_data_reg <= mem[head_idx];
        end
        if (wr_en) begin
            mem[job_idx] <= wr_entry;
        end
    end

    // Entry valid bits: an unwritten row reads as its reset value
    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[job_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg      <= q_item;
            rd_valid_reg <= valid_reg[head_idx];
        end
    end

    // Clamp weight, check for saturation, add the two products
    always_comb begin
        if (rd_valid_reg) begin
            cur = rd_data_reg;
        end else begin
            cur.max_time = '0;
            cur.avg_time = '0;
            cur.weight   = W_FULL;
        end
        if (cur.weight >= W_FULL) begin
            w_clamp = W_FULL;
        end else if (cur.weight <= W_FLOOR) begin
            w_clamp = W_FLOOR;
        end else begin
            w_clamp = cur.weight;
        end
        sat = (AVG_W'(job_reg.cap) > AVG_LIMIT) || (cur.avg_time > AVG_LIMIT);
        acc = prod_a_reg + prod_b_reg;
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_READ: begin
                prod_a_reg  <= ACC_W'(W_FULL - w_clamp) * ACC_W'(cur.avg_time[MUL_IN_W-1:0]);
                prod_b_reg  <= ACC_W'(w_clamp) * ACC_W'(job_reg.cap[MUL_IN_W-1:0]);
                max_new_reg <= (cur.max_time < job_reg.cap) ? job_reg.cap : cur.max_time;
                wt_new_reg  <= sat ? w_clamp : w_clamp - W_STEP;
                sat_reg     <= sat;
            end
            // Divide by 200 as a shift by 3, then a reciprocal multiply by 1/25
            ST_SUM: sum_reg  <= acc[ACC_W-1:3];
            ST_DIV: quot_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP_M);
            default: ;
        endcase
    end

    // Row written back
    assign wr_entry.max_time = max_new_reg;
    assign wr_entry.avg_time = sat_reg ? AVG_SAT : AVG_W'(quot_reg[PROD_W-1:RECIP_SHIFT]);
    assign wr_entry.weight   = wt_new_reg;

    // Latch the watched task's capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            watched_capture_reg <= '0;
        end else if (wr_en && job_reg.hit) begin
            watched_capture_reg <= job_reg.cap;
        end
    end

    // Output register: hold until taken
    always_comb begin
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (job_reg.ok) begin
                m_tdata_reg <= {6'd0, wr_entry.weight, wr_entry.avg_time,
                                wr_entry.max_time, job_reg.cap};
                m_tuser_reg <= {job_reg.hit, 1'b1};
            end else begin
                m_tdata_reg <= '0;
                m_tuser_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg[0]) |-> (m_tdata_reg == '0 && !m_tuser_reg[1]))
        else $error("ignored word carries nonzero result");

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg[0]) |->
            (m_tdata_reg[97:90] >= W_LOW && m_tdata_reg[97:90] <= W_FULL))
        else $error("stored weight out of range");

    a_max_covers_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg[0]) |-> (m_tdata_reg[57:29] >= m_tdata_reg[28:0]))
        else $error("maximum below current capture");

endmodule

[rtl/task_time_max_and_average_core.sv]
// Per-task execution-time monitor: maximum and weighted average per task.
// Input stream: each word reports one task (tuser = 0) or interrupt
// (tuser = 1) completion with its id and its duration in 80 MHz ticks.
// Output stream: one word per input word, in order, with the duration in
// 0.1 us units, the task's updated maximum, average and weight, and flags
// for "table updated" and "watched id". Ignored ids give an all-zero word.
// cfg_we/cfg_wdata write the watched id (256 = none); write only when idle.
// A front stage classifies words into a two-word queue; a back sequencer
// does the table read-modify-write: table read, products, sum, reciprocal
// divide, then write-back and the output register; an ignored id goes from
// the queue straight to the output register. The sequencer pops the next
// word only once the last one is loaded there, which waits on a held output.
// At reset all rows read as max 0, average 0, weight 200 via per-row valid
// bits, and the block accepts at once. When the receiver stalls the result
// holds in the output register, the queue fills, then s_tready drops.
module task_time_max_and_average_core
    import ttma_pkg::*;
#(
    parameter int unsigned NUM_TASKS        = 32,
    parameter int unsigned NUM_IRQ_CHANNELS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [WATCH_W-1:0]   cfg_wdata,   // watch_id
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,     // task_id [7:0], raw_ticks [39:8]
    input  logic                 s_tuser,     // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // capture_tenth_us [28:0], max_time [57:29],
                                              // average_time [89:58], weight_now [97:90]
    output logic [M_TUSER_W-1:0] m_tuser      // accepted [0], watch_hit [1]
);

    logic    q_push;
    logic    q_pop;
    item_t   q_item_in;
    item_t   q_item_out;
    q_stat_t q_stat;

    ttma_front #(
        .NUM_TASKS        (NUM_TASKS),
        .NUM_IRQ_CHANNELS (NUM_IRQ_CHANNELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_push    (q_push),
        .q_item    (q_item_in),
        .q_stat    (q_stat)
    );

    ttma_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_push     (q_push),
        .q_item_in  (q_item_in),
        .q_pop      (q_pop),
        .q_item_out (q_item_out),
        .q_stat     (q_stat)
    );

    ttma_back #(
        .NUM_TASKS (NUM_TASKS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_item   (q_item_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
